// File: hdl/blpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpm_pkg
// shared result codes and controller/datapath interface structs for the
// binary trie longest prefix match block
// ----------------------------------------------------------------------------
package blpm_pkg;

  // result status codes
  localparam logic [1:0] STATUS_HIT  = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_DONE = 2'd2;
  localparam logic [1:0] STATUS_FULL = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input word, reset walk
    logic rd;         // read current node
    logic eval;       // node record valid, update best match
    logic wr_zero;    // write new zero child
    logic wr_one;     // write new one child
    logic wr_parent;  // mark node split, step into new child pair
    logic wr_hop;     // write final hop of an insert
    logic descend;    // step into existing child
    logic mark_full;  // insert ran out of nodes
    logic res_load;   // load result register
  } blpm_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic mode;       // 1 insert, 0 lookup
    logic last;       // all prefix bits walked
    logic split;      // current node has children
    logic pool_full;  // fewer than two free nodes
    logic out_free;   // result register can take a word
  } blpm_stat_t;

endpackage

// File: hdl/blpm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpm_ctrl
// state machine sequencing reads, splits and hop writes of one trie walk
// ----------------------------------------------------------------------------
module blpm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  blpm_pkg::blpm_stat_t  stat,
  output blpm_pkg::blpm_cmd_t   cmd,
  output logic                  busy
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_READ   = 8'b0000_0010,
    S_EVAL   = 8'b0000_0100,
    S_WR0    = 8'b0000_1000,
    S_WR1    = 8'b0001_0000,
    S_WRP    = 8'b0010_0000,
    S_WRHOP  = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (!stat.mode) begin
          if (stat.last || !stat.split) begin
            state_next = S_RESULT;
          end else begin
            cmd.descend = 1'b1;
            state_next  = S_READ;
          end
        end else if (stat.last) begin
          state_next = S_WRHOP;
        end else if (stat.split) begin
          cmd.descend = 1'b1;
          state_next  = S_READ;
        end else if (stat.pool_full) begin
          cmd.mark_full = 1'b1;
          state_next    = S_RESULT;
        end else begin
          state_next = S_WR0;
        end
      end
      S_WR0: begin
        cmd.wr_zero = 1'b1;
        state_next  = S_WR1;
      end
      S_WR1: begin
        cmd.wr_one = 1'b1;
        state_next = S_WRP;
      end
      S_WRP: begin
        cmd.wr_parent = 1'b1;
        state_next    = S_READ;
      end
      S_WRHOP: begin
        cmd.wr_hop = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/blpm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpm_datapath
// node memory, walk registers, free pointer and result register
// ----------------------------------------------------------------------------
module blpm_datapath #(
  parameter int NODES     = 1024,
  parameter int HOP_BITS  = 16,
  parameter int ADDR_BITS = 32,
  parameter int LEN_BITS  = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  blpm_pkg::blpm_cmd_t   cmd,
  output blpm_pkg::blpm_stat_t  stat,
  input  logic                  mode,
  input  logic [ADDR_BITS-1:0]  address,
  input  logic [LEN_BITS-1:0]   prefix_len,
  input  logic [HOP_BITS-1:0]   next_hop,
  input  logic                  hop_valid,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [1:0]            status,
  output logic [HOP_BITS-1:0]   found_hop
);

  localparam int IDX_BITS  = $clog2(NODES);
  localparam int FREE_BITS = IDX_BITS + 1;

  typedef struct packed {
    logic                valid;
    logic [HOP_BITS-1:0] hop;
    logic                split;
    logic [IDX_BITS-1:0] zchild;
  } node_t;

  node_t mem [NODES];
  node_t mem_q;
  node_t rec;
  node_t wdata;
  logic [IDX_BITS-1:0] mem_addr;
  logic                mem_wr;
  logic                root_init;

  // walk registers
  logic                 mode_r;
  logic [ADDR_BITS-1:0] addr_sh;
  logic [LEN_BITS-1:0]  len_sat;
  logic [LEN_BITS-1:0]  level;
  logic [HOP_BITS-1:0]  hop_r;
  logic                 hv_r;
  logic [IDX_BITS-1:0]  cur_node;
  logic [FREE_BITS-1:0] free_index;
  logic                 hit;
  logic [HOP_BITS-1:0]  best;
  logic                 full_flag;
  logic                 out_free;
  logic [IDX_BITS-1:0]  walk_bit;

  assign walk_bit = IDX_BITS'(addr_sh[ADDR_BITS-1]);
  assign out_free = !out_valid || !out_stall;

  // root reads as empty after reset until first written, other nodes are written before first use
  assign rec = (cur_node == '0 && !root_init) ? '0 : mem_q;

  assign mem_wr = cmd.wr_zero || cmd.wr_one || cmd.wr_parent || cmd.wr_hop;

  always_comb begin
    mem_addr = cur_node;
    wdata    = rec;
    if (cmd.wr_zero) begin
      mem_addr    = free_index[IDX_BITS-1:0];
      wdata.split = 1'b0;
    end else if (cmd.wr_one) begin
      mem_addr    = free_index[IDX_BITS-1:0] + IDX_BITS'(1);
      wdata.split = 1'b0;
    end else if (cmd.wr_parent) begin
      wdata.valid  = 1'b0;
      wdata.hop    = '0;
      wdata.split  = 1'b1;
      wdata.zchild = free_index[IDX_BITS-1:0];
    end else if (cmd.wr_hop) begin
      wdata.valid = hv_r;
      wdata.hop   = hv_r ? hop_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[mem_addr] <= wdata;
    end
    if (cmd.rd) begin
      mem_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_init <= 1'b0;
    end else if (mem_wr && mem_addr == '0) begin
      root_init <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_index <= FREE_BITS'(1);
    end else if (cmd.wr_parent) begin
      free_index <= free_index + FREE_BITS'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= mode;
      addr_sh   <= address;
      len_sat   <= (prefix_len > LEN_BITS'(ADDR_BITS)) ? LEN_BITS'(ADDR_BITS) : prefix_len;
      level     <= '0;
      hop_r     <= next_hop;
      hv_r      <= hop_valid;
      cur_node  <= '0;
      hit       <= 1'b0;
      best      <= '0;
      full_flag <= 1'b0;
    end else begin
      if (cmd.eval && !mode_r && rec.valid) begin
        hit  <= 1'b1;
        best <= rec.hop;
      end
      if (cmd.mark_full) begin
        full_flag <= 1'b1;
      end
      if (cmd.wr_parent || cmd.descend) begin
        cur_node <= (cmd.wr_parent ? free_index[IDX_BITS-1:0] : rec.zchild) + walk_bit;
        addr_sh  <= {addr_sh[ADDR_BITS-2:0], 1'b0};
        level    <= level + LEN_BITS'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (mode_r) begin
        status    <= full_flag ? blpm_pkg::STATUS_FULL : blpm_pkg::STATUS_DONE;
        found_hop <= '0;
      end else begin
        status    <= hit ? blpm_pkg::STATUS_HIT : blpm_pkg::STATUS_MISS;
        found_hop <= hit ? best : '0;
      end
    end
  end

  always_comb begin
    stat.mode      = mode_r;
    stat.last      = (level == len_sat);
    stat.split     = rec.split;
    stat.pool_full = (free_index > FREE_BITS'(NODES - 2));
    stat.out_free  = out_free;
  end

`ifndef SYNTHESIS
  a_one_port: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rd && mem_wr))
    else $error("node memory read and write in one cycle");

  a_free_odd: assert property (@(posedge clk) disable iff (rst)
    free_index[0] == 1'b1)
    else $error("free pointer lost pair alignment");

  a_split_room: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_parent |-> (free_index <= FREE_BITS'(NODES - 2)))
    else $error("split issued with no free node pair");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.descend || cmd.wr_parent) |-> (level < len_sat))
    else $error("walk stepped past prefix length");

  a_res_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> out_valid)
    else $error("result word not presented after load");
`endif

endmodule

// File: hdl/binary_trie_longest_prefix_match_top.sv
`timescale 1ns / 1ps
// lookup: a read and an evaluate step per node visited, then the result load
// insert: read, evaluate per node; zero, one, parent writes per split; then hop write
// throughput: one word at a time, set by the single-port node memory walk
// reset: root node reads as empty, free pointer goes to 1, no clearing pass
// a finished result waits in the output register while the next word is taken
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match_top
// longest prefix match routing table kept as a leaf-pushed binary trie
// ----------------------------------------------------------------------------
module binary_trie_longest_prefix_match_top #(
  parameter int NODES     = 1024,
  parameter int HOP_BITS  = 16,
  parameter int ADDR_BITS = 32,
  localparam int LEN_BITS = $clog2(ADDR_BITS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  // input word channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 mode,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [LEN_BITS-1:0]  prefix_len,
  input  logic [HOP_BITS-1:0]  next_hop,
  input  logic                 hop_valid,
  // result word channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic [HOP_BITS-1:0]  found_hop
);

  blpm_pkg::blpm_cmd_t  cmd;
  blpm_pkg::blpm_stat_t stat;
  logic                 busy;

  // new word is taken only while the walker is idle
  assign in_stall = busy;

  // sequencer: one read/evaluate pair per trie level, split writes on insert
  blpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // node pool, walk state and result register
  blpm_datapath #(
    .NODES     (NODES),
    .HOP_BITS  (HOP_BITS),
    .ADDR_BITS (ADDR_BITS),
    .LEN_BITS  (LEN_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .mode       (mode),
    .address    (address),
    .prefix_len (prefix_len),
    .next_hop   (next_hop),
    .hop_valid  (hop_valid),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .status     (status),
    .found_hop  (found_hop)
  );

endmodule
